@@ src/kst_pkg.sv @@
package kst_pkg;

    // Field widths of one request and one response
    localparam int unsigned OP_W     = 2;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned ITEM_W   = 16;
    localparam int unsigned DIR_W    = 8;
    localparam int unsigned LOOPREQ_W = 16;
    localparam int unsigned SLOT_W   = 6;

    // Stored widths
    localparam int unsigned DIRST_W  = 3;
    localparam int unsigned LOOP_W   = 17;

    // Stream widths
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned S_USER_W = 2;
    localparam int unsigned M_DATA_W = 8;
    localparam int unsigned M_USER_W = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PLAY      = 2'd0;
    localparam logic [OP_W-1:0] OP_PLAY_LOOP = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP      = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY     = 2'd3;

    // Loop count stored for "loop forever" (-1 in 17 bits)
    localparam logic [LOOP_W-1:0] LOOP_FOREVER = {LOOP_W{1'b1}};

    typedef struct packed {
        logic [LOOP_W-1:0]  loops_left;
        logic [DIRST_W-1:0] direction;
        logic [ITEM_W-1:0]  item_id;
        logic               playing;
        logic [KEY_W-1:0]   owner_key;
    } entry_t;

    typedef struct packed {
        logic [LOOPREQ_W-1:0] loop_request;
        logic [DIR_W-1:0]     direction;
        logic [ITEM_W-1:0]    item_id;
        logic [KEY_W-1:0]     owner_key;
        logic [OP_W-1:0]      operation;
    } request_t;

    typedef struct packed {
        logic              success;
        logic [SLOT_W-1:0] slot_index;
    } response_t;

endpackage

@@ src/kst_mem.sv @@
module kst_mem #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output kst_pkg::entry_t      rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  kst_pkg::entry_t      wr_data
);

    kst_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/kst_ctrl.sv @@
module kst_ctrl #(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned IDX_W       = 6,
    parameter int unsigned CNT_W       = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  kst_pkg::request_t    req,
    output logic                 rd_en,
    output logic [IDX_W-1:0]     rd_addr,
    input  kst_pkg::entry_t      rd_data,
    output logic                 wr_en,
    output logic [IDX_W-1:0]     wr_addr,
    output kst_pkg::entry_t      wr_data,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output kst_pkg::response_t   rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int unsigned LOOP_W_L = kst_pkg::LOOP_W;

    logic [1:0]         state_reg, state_next;
    kst_pkg::request_t  req_reg;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               match_reg, match_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    logic               is_play;
    logic               key_eq;
    logic               hit;
    logic               room;
    logic [IDX_W-1:0]   play_slot;
    logic               play_ok;
    logic [LOOP_W_L-1:0] loop_val;

    assign is_play = (req_reg.operation == kst_pkg::OP_PLAY) ||
                     (req_reg.operation == kst_pkg::OP_PLAY_LOOP);
    assign key_eq  = (rd_data.owner_key == req_reg.owner_key);
    assign hit     = cmp_valid_reg && key_eq &&
                     ((req_reg.operation != kst_pkg::OP_QUERY) || rd_data.playing);
    assign room    = (used_reg < CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        if (match_reg)
        begin
            play_slot = match_idx_reg;
        end
        else if (free_reg)
        begin
            play_slot = free_idx_reg;
        end
        else
        begin
            play_slot = used_reg[IDX_W-1:0];
        end
    end

    assign play_ok = match_reg || free_reg || room;

    always_comb
    begin
        if (req_reg.operation != kst_pkg::OP_PLAY_LOOP)
        begin
            loop_val = '0;
        end
        else if (req_reg.loop_request == '0)
        begin
            loop_val = kst_pkg::LOOP_FOREVER;
        end
        else
        begin
            loop_val = LOOP_W_L'(req_reg.loop_request);
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = 1'b0;
        match_next     = match_reg;
        match_idx_next = match_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = match_idx_reg;
        wr_data        = '0;
        rsp            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    rd_idx_next = '0;
                    match_next  = 1'b0;
                    free_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // record the first free entry met by a play
                if (cmp_valid_reg && is_play && !free_reg &&
                    (rd_data.owner_key == '0))
                begin
                    free_next     = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end
                if (hit)
                begin
                    match_next     = 1'b1;
                    match_idx_next = cmp_idx_reg;
                    state_next     = ST_DONE;
                end
                else if (rd_idx_reg < used_reg)
                begin
                    rd_en          = 1'b1;
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                    cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (is_play)
                begin
                    rsp.success    = play_ok;
                    rsp.slot_index = play_ok ? kst_pkg::SLOT_W'(play_slot) : '0;
                    wr_addr              = play_slot;
                    wr_data.owner_key    = req_reg.owner_key;
                    wr_data.playing      = 1'b1;
                    wr_data.item_id      = req_reg.item_id;
                    wr_data.direction    = req_reg.direction[kst_pkg::DIRST_W-1:0];
                    wr_data.loops_left   = loop_val;
                end
                else
                begin
                    rsp.success    = match_reg;
                    rsp.slot_index = match_reg ? kst_pkg::SLOT_W'(match_idx_reg) : '0;
                end
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                    if (is_play && play_ok)
                    begin
                        wr_en = 1'b1;
                        if (!match_reg && !free_reg)
                        begin
                            used_next = used_reg + CNT_W'(1);
                        end
                    end
                    else if ((req_reg.operation == kst_pkg::OP_STOP) && match_reg)
                    begin
                        // clear the entry; shrink only when it was the last one
                        wr_en = 1'b1;
                        if (CNT_W'(match_idx_reg) + CNT_W'(1) == used_reg)
                        begin
                            used_next = used_reg - CNT_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cmp_valid_reg <= cmp_valid_next;
            match_reg     <= match_next;
            free_reg      <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
    end

endmodule

@@ src/keyed_slot_table_core.sv @@
// Keyed slot table: an associative table of owner keys (key 0 marks a free
// entry) with a count of entries in use.
//
// Input stream (s_*): one request item per handshake. s_tuser carries the
// operation (play, play with loop count, stop, query); s_tdata carries owner
// key, item id, direction and loop request. Output stream (m_*): exactly one
// response item per request, with success in m_tuser and the entry index in
// m_tdata.
//
// Timing: a request scans the used entries through the table memory, one
// read per cycle with the compare in the cycle after each read, and stops at
// the first match. One request is in work at a time; s_tready is high only
// while the scanner is idle.
//
// Reset clears the entry count, so the table starts empty; the memory itself
// is not cleared and needs no clearing pass. The response sits in an output
// register: the scanner hands over into it while it is empty or draining, so
// a new request is accepted while a response still waits. A stalled m_tready
// holds the finished result and the scanner waits in its final state.
module keyed_slot_table_core #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] owner_key, [47:32] item_id, [55:48] direction, [71:56] loop_request
    input  logic [kst_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] operation
    input  logic [kst_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [5:0] slot_index, [7:6] zero
    output logic [kst_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] success
    output logic [kst_pkg::M_USER_W-1:0]  m_tuser
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    kst_pkg::request_t  req;
    kst_pkg::response_t rsp;
    logic               rsp_valid;
    logic               rsp_ready;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    kst_pkg::entry_t    rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    kst_pkg::entry_t    wr_data;

    logic               out_valid_reg;
    kst_pkg::response_t out_rsp_reg;

    // unpack the request
    assign req.operation    = s_tuser[1:0];
    assign req.owner_key    = s_tdata[31:0];
    assign req.item_id      = s_tdata[47:32];
    assign req.direction    = s_tdata[55:48];
    assign req.loop_request = s_tdata[71:56];

    kst_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    kst_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // output register: load when empty or being drained
    assign rsp_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= rsp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_ready && rsp_valid)
        begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = kst_pkg::M_DATA_W'(out_rsp_reg.slot_index);
    assign m_tuser  = out_rsp_reg.success;

endmodule

@@ src/kst_checker.sv @@
module kst_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [kst_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [kst_pkg::S_USER_W-1:0]  s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [kst_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic [kst_pkg::M_USER_W-1:0]  m_tuser
);

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("response changed while stalled");

    // a failed request reports entry zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("failure with nonzero slot index");

    // one request in work at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one in work");

    // a new response only comes out of a request in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("response without a request in work");

endmodule

bind keyed_slot_table_core kst_checker u_kst_checker (.*);

@@ sim/slot_table_checker.sv @@
module slot_table_checker
    import kst_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic [S_USER_W-1:0]  s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic [M_USER_W-1:0]  m_tuser,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the table and its fill level
    entry_t    slot_tab [TABLE_DEPTH];
    int        entries_used;
    int        failures;
    response_t expected_q [$];
    response_t seen;
    response_t want;

    // Apply one request to the shadow table and return its response
    function automatic response_t predict_response(input request_t req);
        response_t rsp;
        int        slot;
        int        i;
        bit        hit;
        rsp  = '0;
        slot = -1;
        hit  = 1'b0;
        case (req.operation)
            OP_PLAY, OP_PLAY_LOOP:
            begin
                // a matching key wins, else the first free entry seen
                for (i = 0; i < entries_used && !hit; i++)
                begin
                    if (slot_tab[i].owner_key == req.owner_key)
                    begin
                        slot = i;
                        hit  = 1'b1;
                    end
                    else if (slot_tab[i].owner_key == '0 && slot < 0)
                        slot = i;
                end
                if (slot < 0 && entries_used < TABLE_DEPTH)
                begin
                    slot = entries_used;
                    entries_used++;
                end
                if (slot >= 0)
                begin
                    slot_tab[slot].owner_key = req.owner_key;
                    slot_tab[slot].item_id   = req.item_id;
                    slot_tab[slot].direction = req.direction[DIRST_W-1:0];
                    slot_tab[slot].playing   = 1'b1;
                    if (req.operation == OP_PLAY_LOOP && req.loop_request == '0)
                        slot_tab[slot].loops_left = LOOP_FOREVER;
                    else if (req.operation == OP_PLAY_LOOP)
                        slot_tab[slot].loops_left = {1'b0, req.loop_request};
                    else
                        slot_tab[slot].loops_left = '0;
                    rsp.success    = 1'b1;
                    rsp.slot_index = slot[SLOT_W-1:0];
                end
            end
            OP_STOP:
            begin
                for (i = 0; i < entries_used && !hit; i++)
                begin
                    if (slot_tab[i].owner_key == req.owner_key)
                    begin
                        slot_tab[i] = '0;
                        // shrink only when the last entry in use goes away
                        if (i + 1 == entries_used)
                            entries_used--;
                        hit            = 1'b1;
                        rsp.success    = 1'b1;
                        rsp.slot_index = i[SLOT_W-1:0];
                    end
                end
            end
            default:
            begin
                for (i = 0; i < entries_used && !hit; i++)
                begin
                    if (slot_tab[i].owner_key == req.owner_key && slot_tab[i].playing)
                    begin
                        hit            = 1'b1;
                        rsp.success    = 1'b1;
                        rsp.slot_index = i[SLOT_W-1:0];
                    end
                end
            end
        endcase
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_used = 0;
            failures     = 0;
            foreach (slot_tab[i])
                slot_tab[i] = '0;
            expected_q.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // retire the response first: it always belongs to an older request
            if (m_tvalid && m_tready)
            begin
                seen.success    = m_tuser[0];
                seen.slot_index = m_tdata[SLOT_W-1:0];
                if (expected_q.size() == 0)
                begin
                    $error("unexpected response: success %0b slot_index %0d",
                           seen.success, seen.slot_index);
                    failures++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (seen.success !== want.success)
                    begin
                        $error("success: expected %0b, actual %0b",
                               want.success, seen.success);
                        failures++;
                    end
                    if (seen.slot_index !== want.slot_index)
                    begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, seen.slot_index);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_response(request_t'({s_tdata, s_tuser})));
            pending    <= expected_q.size();
            fail_count <= failures;
        end
    end

endmodule

@@ sim/tb.sv @@
module tb();
    timeunit 1ns;
    timeprecision 1ps;
    import kst_pkg::*;

    // Run shape
    localparam int ITEM_TARGET    = 800;
    localparam int CALM_ITEMS     = 100;   // tail of the run with no idling
    localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 80;    // longer than a full-table scan
    localparam int FILL_KEYS      = 70;    // more than the table holds
    localparam int CHURN_ITEMS    = 40;
    localparam int NOISE_ITEMS    = 15;
    localparam int POOL_KEYS      = 6;

    // Directed keys: the key extremes, single-bit keys and two ordinary ones
    localparam logic [KEY_W-1:0] KEY_ZERO = 32'h0000_0000;
    localparam logic [KEY_W-1:0] KEY_ONES = 32'hFFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ONE  = 32'h0000_0001;
    localparam logic [KEY_W-1:0] KEY_MSB  = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MID  = 32'h1234_5678;
    localparam logic [KEY_W-1:0] KEY_ALT  = 32'h5555_5555;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // [31:0] owner_key, [47:32] item_id, [55:48] direction, [71:56] loop_request
    logic [S_DATA_W-1:0] s_tdata;
    // [1:0] operation
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // [5:0] slot_index, [7:6] zero
    logic [M_DATA_W-1:0] m_tdata;
    // [0] success
    logic [M_USER_W-1:0] m_tuser;

    int fail_count;
    int pending;

    // Run state; calm, rx_idle_pct and long_hold_req are shared with the response side
    int sent;
    int op_count [4];
    int fill_passes;
    int drain_pauses;
    int tx_idle_pct;
    int rx_idle_pct;
    bit calm;
    bit long_hold_req;

    keyed_slot_table_core #(
        .TABLE_DEPTH(64)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    slot_table_checker #(
        .TABLE_DEPTH(64)
    ) checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic request_t make_request(input logic [OP_W-1:0]      op,
                                              input logic [KEY_W-1:0]     key,
                                              input logic [ITEM_W-1:0]    item,
                                              input logic [DIR_W-1:0]     dir,
                                              input logic [LOOPREQ_W-1:0] loops);
        request_t req;
        req.operation    = op;
        req.owner_key    = key;
        req.item_id      = item;
        req.direction    = dir;
        req.loop_request = loops;
        return req;
    endfunction

    // Random payload; the loop request lands on its extremes now and then
    function automatic request_t random_request(input logic [OP_W-1:0]  op,
                                                input logic [KEY_W-1:0] key);
        logic [LOOPREQ_W-1:0] loops;
        int                   pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            loops = '0;
        else if (pick == 1)
            loops = '1;
        else
            loops = LOOPREQ_W'($urandom_range(0, 65535));
        return make_request(op, key, ITEM_W'($urandom_range(0, 65535)),
                            DIR_W'($urandom_range(0, 255)), loops);
    endfunction

    // Weighted mix: plays (either kind) half the time, stops and queries a quarter each
    function automatic logic [OP_W-1:0] pick_operation();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return OP_PLAY;
        else if (pick < 50)
            return OP_PLAY_LOOP;
        else if (pick < 75)
            return OP_STOP;
        else
            return OP_QUERY;
    endfunction

    // Idle rate for one phase: none, light or heavy
    function automatic int pick_idle();
        int pick;
        pick = $urandom_range(0, 2);
        return (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
    endfunction

    function automatic logic [KEY_W-1:0] pool_entry();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return KEY_ZERO;
        else if (pick == 1)
            return KEY_ONES;
        else
            return $urandom;
    endfunction

    // Offer one item and hold it until the block takes it. An idle burst may
    // come first; s_tvalid only drops where no item follows in the same step.
    task automatic offer_request(input request_t req);
        if (!calm && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tdata  <= {req.loop_request, req.direction, req.item_id, req.owner_key};
        s_tuser  <= req.operation;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
        op_count[req.operation]++;
        calm = (sent >= ITEM_TARGET - CALM_ITEMS);
    endtask

    // Stop offering and wait until every response is back. pending is
    // updated at the edge, so the first look is taken after the edge that takes the last item.
    task automatic drain_responses();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Response side: random stall bursts, plus one long hold-off on request
    // from the request side so the block fills up and drops s_tready.
    initial
    begin : receiver
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                stall = 0;
                while (stall < LONG_HOLD)
                begin
                    @(posedge clk);
                    stall++;
                end
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < rx_idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no handshake happens on either side for
    // too long. The long hold-off and a full-table scan fit well inside.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no handshake for %0d cycles, %0d responses outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0] key_pool [POOL_KEYS];
        logic [KEY_W-1:0] fill_key [FILL_KEYS];
        int               i;
        int               kind;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        sent          = 0;
        fill_passes   = 0;
        drain_pauses  = 0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        foreach (op_count[k])
            op_count[k] = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed part: walk the table through its corner cases ----
        // empty table: query and stop find nothing
        offer_request(make_request(OP_QUERY, KEY_ONES, 16'h0000, 8'h00, 16'h0000));
        offer_request(make_request(OP_STOP, KEY_ONES, 16'h0000, 8'h00, 16'h0000));
        // appends with field extremes, loop forever and the largest loop count
        offer_request(make_request(OP_PLAY, KEY_ONES, 16'hFFFF, 8'hFF, 16'hFFFF));
        offer_request(make_request(OP_PLAY_LOOP, KEY_ONE, 16'h0000, 8'h00, 16'h0000));
        offer_request(make_request(OP_PLAY_LOOP, KEY_MSB, 16'h8001, 8'h07, 16'hFFFF));
        offer_request(make_request(OP_QUERY, KEY_ONES, 16'h0000, 8'h00, 16'h0000));
        // replay of a present key overwrites its own entry
        offer_request(make_request(OP_PLAY, KEY_ONES, 16'h1234, 8'h08, 16'h0001));
        // stop in the middle leaves a free entry and keeps the count
        offer_request(make_request(OP_STOP, KEY_ONE, 16'h0000, 8'h00, 16'h0000));
        offer_request(make_request(OP_QUERY, KEY_ONE, 16'h0000, 8'h00, 16'h0000));
        // key zero meets the stopped entry, which no longer plays
        offer_request(make_request(OP_QUERY, KEY_ZERO, 16'h0000, 8'h00, 16'h0000));
        // a new key reuses the free entry
        offer_request(make_request(OP_PLAY, KEY_MID, 16'hA5A5, 8'hF8, 16'h0000));
        // stop of the last entry shrinks the count
        offer_request(make_request(OP_STOP, KEY_MSB, 16'h0000, 8'h00, 16'h0000));
        // key zero as an owner: append, find it playing, stop it twice
        offer_request(make_request(OP_PLAY, KEY_ZERO, 16'h00FF, 8'h80, 16'h0000));
        offer_request(make_request(OP_QUERY, KEY_ZERO, 16'h0000, 8'h00, 16'h0000));
        offer_request(make_request(OP_STOP, KEY_ZERO, 16'h0000, 8'h00, 16'h0000));
        offer_request(make_request(OP_STOP, KEY_ZERO, 16'h0000, 8'h00, 16'h0000));
        // free the first entry, then stop key zero on the free entry again
        offer_request(make_request(OP_STOP, KEY_ONES, 16'h0000, 8'h00, 16'h0000));
        offer_request(make_request(OP_STOP, KEY_ZERO, 16'h0000, 8'h00, 16'h0000));
        offer_request(make_request(OP_PLAY_LOOP, KEY_ZERO, 16'h5A5A, 8'h55, 16'h0001));
        offer_request(make_request(OP_QUERY, KEY_MID, 16'h0000, 8'h00, 16'h0000));
        offer_request(make_request(OP_STOP, KEY_MID, 16'h0000, 8'h00, 16'h0000));
        offer_request(make_request(OP_PLAY_LOOP, KEY_ALT, 16'h5555, 8'hAA, 16'hAAAA));
        offer_request(make_request(OP_QUERY, KEY_ALT, 16'hFFFF, 8'hFF, 16'hFFFF));

        // hold the sender until the block is empty
        drain_responses();
        drain_pauses++;

        // seed the key pool so a noise phase has keys before any churn phase
        foreach (key_pool[k])
            key_pool[k] = pool_entry();

        // ---- Random part: phases of churn, table fills and noise ----
        while (sent < ITEM_TARGET)
        begin
            tx_idle_pct = pick_idle();
            rx_idle_pct = pick_idle();
            kind = (fill_passes == 0) ? 7 : $urandom_range(0, 7);

            if (kind <= 4)
            begin
                // churn: a few keys played, queried and stopped in any order
                foreach (key_pool[k])
                    key_pool[k] = pool_entry();
                repeat (CHURN_ITEMS)
                    offer_request(random_request(pick_operation(),
                                                 key_pool[$urandom_range(0, POOL_KEYS - 1)]));
            end
            else if (kind <= 6)
            begin
                // noise: any operation on mostly unknown keys
                repeat (NOISE_ITEMS)
                    offer_request(random_request(OP_W'($urandom_range(0, 3)),
                                  ($urandom_range(0, 3) == 0) ? key_pool[0] : $urandom));
            end
            else
            begin
                // fill: more plays than the table holds, so the last ones are
                // refused; then mixed traffic on a full table; then stop all
                // from the top down so the count shrinks step by step
                foreach (fill_key[k])
                    fill_key[k] = $urandom;
                for (i = 0; i < FILL_KEYS; i++)
                begin
                    if (fill_passes == 0 && i == 10)
                        long_hold_req = 1'b1;
                    offer_request(random_request(($urandom_range(0, 1) == 0) ?
                                                 OP_PLAY : OP_PLAY_LOOP, fill_key[i]));
                end
                repeat (30)
                    offer_request(random_request(pick_operation(),
                                                 fill_key[$urandom_range(0, FILL_KEYS - 1)]));
                for (i = FILL_KEYS - 1; i >= 0; i--)
                    offer_request(random_request(OP_STOP, fill_key[i]));
                fill_passes++;
            end

            if ($urandom_range(0, 2) == 0)
            begin
                drain_responses();
                drain_pauses++;
            end
        end

        // ---- End of run: collect the tail, let the block settle ----
        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d play, %0d play-loop, %0d stop, %0d query",
                 sent, op_count[OP_PLAY], op_count[OP_PLAY_LOOP],
                 op_count[OP_STOP], op_count[OP_QUERY]);
        $display("Table filled past capacity %0d times, %0d-cycle receiver hold-off, %0d drains",
                 fill_passes, LONG_HOLD, drain_pauses);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
